@@ rtl/jssp_pkg.sv @@
`timescale 1ns / 1ps
package jssp_pkg;

   // Characters that steer the parser
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;

   // Event queue between parser and output side
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   // Per-level parse state
   typedef enum logic [2:0] {
      LS_START  = 3'd0,
      LS_KEY    = 3'd1,
      LS_COLON  = 3'd2,
      LS_CHOOSE = 3'd3,
      LS_STRING = 3'd4,
      LS_NUMBER = 3'd5,
      LS_ARRAY  = 3'd6,
      LS_NEXT   = 3'd7
   } ls_type;

   // Event codes
   typedef enum logic [3:0] {
      EV_KEY_CHAR  = 4'd0,
      EV_KEY_DONE  = 4'd1,
      EV_STR_CHAR  = 4'd2,
      EV_STR_DONE  = 4'd3,
      EV_NUMBER    = 4'd4,
      EV_ELEMENT   = 4'd5,
      EV_OBJ_OPEN  = 4'd6,
      EV_OBJ_CLOSE = 4'd7,
      EV_DOC_CLOSE = 4'd8,
      EV_OVERFLOW  = 4'd9,
      EV_DOC_OPEN  = 4'd10
   } ev_code_type;

   // One event; code in the lowest bits, then the output tdata fields from the lowest bit up
   typedef struct packed {
      logic [4:0]  len;
      logic [15:0] idx;
      logic [31:0] num;
      logic [7:0]  chr;
      logic [2:0]  depth;
      ev_code_type code;
   } ev_type;

   // All events of one byte: a full first event and an optional structural second one
   typedef struct packed {
      logic        two;
      ev_code_type ev1_code;
      logic [2:0]  ev1_depth;
      ev_type      ev0;
   } entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Low three bits of a level number
   function automatic logic [2:0] dep3(input logic [15:0] v);
      return v[2:0];
   endfunction

endpackage

@@ rtl/jssp_front.sv @@
`timescale 1ns / 1ps
module jssp_front #(
   parameter int MAX_DEPTH = 5,
   parameter int MAX_TEXT  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  jssp_pkg::qstat_type q_stat,
   output logic               push,
   output jssp_pkg::entry_type push_entry
);
   import jssp_pkg::*;

   localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int TW = $clog2(MAX_TEXT);

   logic              in_doc_ff, in_doc_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   ls_type            ls_ff [MAX_DEPTH];
   logic [15:0]       pos_ff [MAX_DEPTH];
   logic [31:0]       acc_ff, acc_in;
   logic [TW-1:0]     kpos_ff, kpos_in;
   logic [TW-1:0]     spos_ff, spos_in;

   logic [LW-1:0]     lv, lv_up;
   ls_type            cur, ls_new;
   logic [15:0]       pos_cur, pos_new;
   logic              open_wr;
   logic [7:0]        c;
   logic              is_dig;
   logic [31:0]       acc10, dig;
   logic              end_obj, new_obj;
   logic              a_vld, b_vld;
   ev_type            ev_a;
   ev_code_type       b_code;
   logic [2:0]        b_depth;
   logic              accept;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   assign c       = req_tdata;
   assign lv      = lvl_ff;
   assign lv_up   = LW'(16'(lv) + 16'd1);
   assign cur     = ls_ff[lv];
   assign pos_cur = pos_ff[lv];
   assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
   assign dig     = 32'(c - CH_ZERO);
   assign acc10   = (acc_ff << 3) + (acc_ff << 1);

   // Classify the byte against the current level state
   always_comb begin
      in_doc_in = in_doc_ff;
      lvl_in    = lvl_ff;
      ls_new    = cur;
      pos_new   = pos_cur;
      acc_in    = acc_ff;
      kpos_in   = kpos_ff;
      spos_in   = spos_ff;
      open_wr   = 1'b0;
      end_obj   = 1'b0;
      new_obj   = 1'b0;
      a_vld     = 1'b0;
      ev_a      = '0;
      b_vld     = 1'b0;
      b_code    = EV_DOC_CLOSE;
      b_depth   = '0;
      if (!in_doc_ff) begin
         if (c == CH_LBRACE) begin
            in_doc_in = 1'b1;
            lvl_in    = '0;
            a_vld     = 1'b1;
            ev_a.code = EV_DOC_OPEN;
         end
      end else begin
         unique case (cur)
            LS_START: begin
               if (c == CH_QUOTE) begin
                  ls_new  = LS_KEY;
                  kpos_in = '0;
               end else if (c == CH_RBRACE) begin
                  end_obj = 1'b1;
               end
            end
            LS_KEY: begin
               if (c == CH_QUOTE) begin
                  a_vld      = 1'b1;
                  ev_a.code  = EV_KEY_DONE;
                  ev_a.depth = dep3(16'(lv));
                  ev_a.len   = 5'(8'(kpos_ff));
                  ls_new     = LS_COLON;
               end else if (kpos_ff < TW'(MAX_TEXT - 1)) begin
                  kpos_in    = kpos_ff + 1'b1;
                  a_vld      = 1'b1;
                  ev_a.code  = EV_KEY_CHAR;
                  ev_a.depth = dep3(16'(lv));
                  ev_a.chr   = c;
               end
            end
            LS_COLON: begin
               if (c == CH_COLON) ls_new = LS_CHOOSE;
            end
            LS_CHOOSE: begin
               if (c == CH_LBRACE) begin
                  ls_new  = LS_NEXT;
                  new_obj = 1'b1;
               end else if (c == CH_QUOTE) begin
                  ls_new  = LS_STRING;
                  spos_in = '0;
               end else if (c == CH_LBRACK) begin
                  ls_new  = LS_ARRAY;
                  pos_new = '0;
                  acc_in  = '0;
               end else if (is_dig) begin
                  ls_new = LS_NUMBER;
                  acc_in = dig;
               end
            end
            LS_STRING: begin
               if (c == CH_QUOTE) begin
                  a_vld      = 1'b1;
                  ev_a.code  = EV_STR_DONE;
                  ev_a.depth = dep3(16'(lv));
                  ev_a.len   = 5'(8'(spos_ff));
                  ls_new     = LS_NEXT;
               end else if (spos_ff < TW'(MAX_TEXT - 1)) begin
                  spos_in    = spos_ff + 1'b1;
                  a_vld      = 1'b1;
                  ev_a.code  = EV_STR_CHAR;
                  ev_a.depth = dep3(16'(lv));
                  ev_a.chr   = c;
               end
            end
            LS_NUMBER: begin
               if (c == CH_COMMA || c == CH_RBRACE) begin
                  a_vld      = 1'b1;
                  ev_a.code  = EV_NUMBER;
                  ev_a.depth = dep3(16'(lv));
                  ev_a.num   = acc_ff;
                  ls_new     = LS_START;
                  end_obj    = (c == CH_RBRACE);
               end else if (is_dig) begin
                  acc_in = acc10 + dig;
               end
            end
            LS_ARRAY: begin
               if (c == CH_RBRACK || c == CH_COMMA) begin
                  a_vld      = 1'b1;
                  ev_a.code  = EV_ELEMENT;
                  ev_a.depth = dep3(16'(lv));
                  ev_a.num   = acc_ff;
                  ev_a.idx   = pos_cur;
                  if (c == CH_RBRACK) begin
                     ls_new = LS_NEXT;
                  end else begin
                     pos_new = pos_cur + 16'd1;
                     acc_in  = '0;
                  end
               end else if (is_dig) begin
                  acc_in = acc10 + dig;
               end
            end
            LS_NEXT: begin
               if (c == CH_COMMA) begin
                  ls_new = LS_START;
               end else if (c == CH_RBRACE) begin
                  ls_new  = LS_START;
                  end_obj = 1'b1;
               end
            end
         endcase

         // Close or open an object after the level step
         if (end_obj) begin
            b_vld = 1'b1;
            if (lv == '0) begin
               in_doc_in = 1'b0;
               b_code    = EV_DOC_CLOSE;
            end else begin
               b_code  = EV_OBJ_CLOSE;
               b_depth = dep3(16'(lv));
               lvl_in  = lv - 1'b1;
            end
         end else if (new_obj) begin
            b_vld = 1'b1;
            if (16'(lv) >= 16'(MAX_DEPTH - 1)) begin
               b_code  = EV_OVERFLOW;
               b_depth = dep3(16'(lv));
            end else begin
               b_code  = EV_OBJ_OPEN;
               b_depth = dep3(16'(lv) + 16'd1);
               lvl_in  = lv_up;
               open_wr = 1'b1;
            end
         end
      end
   end

   // Pack the byte's events into one queue entry
   always_comb begin
      push_entry = '0;
      if (a_vld) begin
         push_entry.ev0       = ev_a;
         push_entry.two       = b_vld;
         push_entry.ev1_code  = b_code;
         push_entry.ev1_depth = b_depth;
      end else begin
         push_entry.ev0.code  = b_code;
         push_entry.ev0.depth = b_depth;
         push_entry.ev1_code  = b_code;
      end
   end

   assign push = accept && (a_vld || b_vld);

   // Update the parse state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_doc_ff <= 1'b0;
         lvl_ff    <= '0;
         acc_ff    <= '0;
         kpos_ff   <= '0;
         spos_ff   <= '0;
         for (int i = 0; i < MAX_DEPTH; i++) begin
            ls_ff[i]  <= LS_START;
            pos_ff[i] <= '0;
         end
      end else if (accept) begin
         in_doc_ff <= in_doc_in;
         lvl_ff    <= lvl_in;
         acc_ff    <= acc_in;
         kpos_ff   <= kpos_in;
         spos_ff   <= spos_in;
         pos_ff[lv] <= pos_new;
         if (!in_doc_ff) begin
            if (c == CH_LBRACE) ls_ff[0] <= LS_START;
         end else begin
            ls_ff[lv] <= ls_new;
            if (open_wr) ls_ff[lv_up] <= LS_START;
         end
      end
   end

endmodule

@@ rtl/jssp_queue.sv @@
`timescale 1ns / 1ps
module jssp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jssp_pkg::entry_type push_entry,
   input  logic                pop,
   output jssp_pkg::entry_type head,
   output jssp_pkg::qstat_type q_stat
);
   import jssp_pkg::*;

   entry_type      mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   cnt_ff;
   logic           do_push, do_pop;

   assign q_stat.empty = (cnt_ff == '0);
   assign q_stat.full  = (cnt_ff == (QAW + 1)'(QDEPTH));
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = mem_ff[rd_ff];

   // Store the entry at the write pointer
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

@@ rtl/jssp_back.sv @@
`timescale 1ns / 1ps
module jssp_back (
   input  logic                clock,
   input  logic                reset,
   input  jssp_pkg::entry_type head,
   input  jssp_pkg::qstat_type q_stat,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,
   output logic [3:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import jssp_pkg::*;

   logic        vld_ff, vld_in;
   logic        last_ff, last_in;
   ev_type      ev_ff, ev_in;
   logic        sec_ff, sec_in;
   ev_code_type sec_code_ff, sec_code_in;
   logic [2:0]  sec_depth_ff, sec_depth_in;
   logic        load_ok;

   assign load_ok = !vld_ff || rsp_tready;

   // Pick the next event: pending second event first, then the queue head
   always_comb begin
      vld_in       = vld_ff;
      last_in      = last_ff;
      ev_in        = ev_ff;
      sec_in       = sec_ff;
      sec_code_in  = sec_code_ff;
      sec_depth_in = sec_depth_ff;
      pop          = 1'b0;
      if (load_ok) begin
         if (sec_ff) begin
            vld_in      = 1'b1;
            last_in     = 1'b1;
            ev_in       = '0;
            ev_in.code  = sec_code_ff;
            ev_in.depth = sec_depth_ff;
            sec_in      = 1'b0;
         end else if (!q_stat.empty) begin
            pop          = 1'b1;
            vld_in       = 1'b1;
            last_in      = !head.two;
            ev_in        = head.ev0;
            sec_in       = head.two;
            sec_code_in  = head.ev1_code;
            sec_depth_in = head.ev1_depth;
         end else begin
            vld_in = 1'b0;
         end
      end
   end

   // Hold the output transfer until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         sec_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         sec_ff <= sec_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      ev_ff        <= ev_in;
      sec_code_ff  <= sec_code_in;
      sec_depth_ff <= sec_depth_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {ev_ff.len, ev_ff.idx, ev_ff.num, ev_ff.chr, ev_ff.depth};
   assign rsp_tuser  = ev_ff.code;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/json_subset_stream_parser.sv @@
`timescale 1ns / 1ps
// A byte's first event goes through the event queue and the output register to rsp.
// Throughput: one byte per cycle unless the event queue is full; one event leaves
// per cycle unless rsp stalls; a byte with two events needs a further transfer, absorbed
// by the four-entry event queue. The parser state is updated on each accepted byte, so
// consecutive bytes need no gap. Reset (synchronous, active high) returns the parser
// to idle at level zero and empties the queue and output register.
module json_subset_stream_parser #(
   parameter int MAX_DEPTH = 5,
   parameter int MAX_TEXT  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] depth, [10:3] char_value, [42:11] number_value,
   // [58:43] element_index, [63:59] text_length
   output logic [63:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // [3:0] event_res
   output logic        rsp_tlast    // last
);
   import jssp_pkg::*;

   logic      push, pop;
   entry_type push_entry, head;
   qstat_type q_stat;

   // Parse bytes and classify them into events
   jssp_front #(
      .MAX_DEPTH (MAX_DEPTH),
      .MAX_TEXT  (MAX_TEXT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   // Buffer event groups between the two sides
   jssp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // Send events out one per transfer
   jssp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
